>>> rtl/dsl_pkg.sv
package dsl_pkg;

	localparam int SLOT_COUNT = 2;
	localparam int DATA_W = 32;
	localparam int DEST_W = 4;
	localparam int SRC_W = 5;
	localparam int CFG_IDX_W = 4;

	typedef enum logic [1:0] {
		OP_SET  = 2'd0,
		OP_INCR = 2'd1,
		OP_ADD  = 2'd2,
		OP_SUB  = 2'd3
	} op_t;

	typedef struct packed {
		op_t               slot0_op;
		logic [DEST_W-1:0] slot0_dest;
		logic [SRC_W-1:0]  slot0_src_a;
		logic [SRC_W-1:0]  slot0_src_b;
		logic [DATA_W-1:0] slot0_imm;
		op_t               slot1_op;
		logic [DEST_W-1:0] slot1_dest;
		logic [SRC_W-1:0]  slot1_src_a;
		logic [SRC_W-1:0]  slot1_src_b;
		logic [DATA_W-1:0] slot1_imm;
	} in_t;

	typedef struct packed {
		logic              conflict;
		logic              slot0_wrote;
		logic [DATA_W-1:0] slot0_result;
		logic              slot1_wrote;
		logic [DATA_W-1:0] slot1_result;
	} out_t;

	typedef struct packed {
		op_t               op;
		logic [DEST_W-1:0] dest;
		logic [SRC_W-1:0]  src_a;
		logic [SRC_W-1:0]  src_b;
		logic [DATA_W-1:0] imm;
	} slot_t;

	typedef struct packed {
		logic              active;
		logic [DEST_W-1:0] dest;
		logic [DATA_W-1:0] value;
	} lane_res_t;

	typedef struct packed {
		logic              en;
		logic [DEST_W-1:0] dest;
		logic [DATA_W-1:0] data;
	} wr_t;

endpackage

>>> rtl/dual_slot_loop_register_update.sv
// Dual-slot loop register update.
// Each input transaction carries one instruction word with two slot operations
// (set, incr, add, sub) that act together on a file of loop registers. Both
// slots read the file as it stood before the word; sources past the loop
// registers read the control registers, which are loaded through the cfg_we,
// cfg_index and cfg_data write port. The output transaction reports a
// conflict flag and, per slot, whether it wrote and the value written.
// The word is evaluated by two parallel lanes and a merge stage in the cycle
// it is accepted, the file is updated at that edge and the result sits in
// the output register on the next cycle.
// The block takes one word per cycle while the output is not stalled; the
// register file feedback through the 32-bit arithmetic of each lane sets this.
// in_ready stays high while the output register is empty or being drained,
// so a word is accepted in the same cycle that the previous result is taken.
// When the receiver stalls with a result held, in_ready drops and the result holds.
// Reset clears all loop registers, all control registers and the output valid.
module dual_slot_loop_register_update #(
	parameter int LOOP_REG_COUNT = 16,
	parameter int CTL_REG_COUNT = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  dsl_pkg::in_t                      in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output dsl_pkg::out_t                     out_data,
	input  logic                              cfg_we,
	input  logic [dsl_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dsl_pkg::DATA_W-1:0]        cfg_data
);
	import dsl_pkg::*;

	logic [DATA_W-1:0] loop_q [LOOP_REG_COUNT];
	logic [DATA_W-1:0] ctl_q [CTL_REG_COUNT];
	slot_t             slots [SLOT_COUNT];
	lane_res_t         lane [SLOT_COUNT];
	wr_t               wr [SLOT_COUNT];
	out_t              result;
	out_t              out_q;
	logic              out_valid_q;
	logic              accept;

	assign slots[0] = '{op: in_data.slot0_op, dest: in_data.slot0_dest,
		src_a: in_data.slot0_src_a, src_b: in_data.slot0_src_b, imm: in_data.slot0_imm};
	assign slots[1] = '{op: in_data.slot1_op, dest: in_data.slot1_dest,
		src_a: in_data.slot1_src_a, src_b: in_data.slot1_src_b, imm: in_data.slot1_imm};

	for (genvar s = 0; s < SLOT_COUNT; s++) begin : g_lane
		dsl_lane #(
			.LOOP_REG_COUNT(LOOP_REG_COUNT),
			.CTL_REG_COUNT(CTL_REG_COUNT)
		) u_lane (
			.slot(slots[s]),
			.loop_regs(loop_q),
			.ctl_regs(ctl_q),
			.res(lane[s])
		);
	end

	dsl_merge #(
		.LOOP_REG_COUNT(LOOP_REG_COUNT)
	) u_merge (
		.lane(lane),
		.wr(wr),
		.result(result)
	);

	assign in_ready = !out_valid_q || out_ready;
	assign accept = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LOOP_REG_COUNT; i++) begin
				loop_q[i] <= '0;
			end
		end else if (accept) begin
			for (int i = 0; i < LOOP_REG_COUNT; i++) begin
				for (int s = 0; s < SLOT_COUNT; s++) begin
					if (wr[s].en && wr[s].dest == DEST_W'(i)) begin
						loop_q[i] <= wr[s].data;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < CTL_REG_COUNT; k++) begin
				ctl_q[k] <= '0;
			end
		end else if (cfg_we) begin
			for (int k = 0; k < CTL_REG_COUNT; k++) begin
				if (cfg_index == CFG_IDX_W'(k)) begin
					ctl_q[k] <= cfg_data;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= result;
		end
	end

endmodule

>>> rtl/dsl_lane.sv
module dsl_lane #(
	parameter int LOOP_REG_COUNT = 16,
	parameter int CTL_REG_COUNT = 8
) (
	input  dsl_pkg::slot_t                    slot,
	input  logic [dsl_pkg::DATA_W-1:0]        loop_regs [LOOP_REG_COUNT],
	input  logic [dsl_pkg::DATA_W-1:0]        ctl_regs [CTL_REG_COUNT],
	output dsl_pkg::lane_res_t                res
);
	import dsl_pkg::*;

	localparam int LIDX_W = (LOOP_REG_COUNT > 1) ? $clog2(LOOP_REG_COUNT) : 1;
	localparam int CIDX_W = (CTL_REG_COUNT > 1) ? $clog2(CTL_REG_COUNT) : 1;

	function automatic logic [DATA_W-1:0] read_src(
		input logic [SRC_W-1:0]  idx,
		input logic [DATA_W-1:0] lr [LOOP_REG_COUNT],
		input logic [DATA_W-1:0] cr [CTL_REG_COUNT]
	);
		logic [SRC_W-1:0] off;
		off = idx - SRC_W'(LOOP_REG_COUNT);
		if (idx < SRC_W'(LOOP_REG_COUNT)) begin
			return lr[idx[LIDX_W-1:0]];
		end else if (off < SRC_W'(CTL_REG_COUNT)) begin
			return cr[off[CIDX_W-1:0]];
		end else begin
			return '0;
		end
	endfunction

	logic [DATA_W-1:0] a_val;
	logic [DATA_W-1:0] b_val;
	logic [DATA_W-1:0] d_val;

	always_comb begin
		a_val = read_src(slot.src_a, loop_regs, ctl_regs);
		b_val = read_src(slot.src_b, loop_regs, ctl_regs);
		d_val = read_src({1'b0, slot.dest}, loop_regs, ctl_regs);
		res.dest = slot.dest;
		res.active = !(slot.op == OP_INCR && slot.imm == '0);
		case (slot.op)
			OP_SET: res.value = slot.imm;
			OP_INCR: res.value = d_val + slot.imm;
			OP_ADD: res.value = a_val + b_val;
			OP_SUB: res.value = a_val - b_val;
			default: res.value = '0;
		endcase
	end

endmodule

>>> rtl/dsl_merge.sv
module dsl_merge #(
	parameter int LOOP_REG_COUNT = 16
) (
	input  dsl_pkg::lane_res_t lane [dsl_pkg::SLOT_COUNT],
	output dsl_pkg::wr_t       wr [dsl_pkg::SLOT_COUNT],
	output dsl_pkg::out_t      result
);
	import dsl_pkg::*;

	logic conflict;

	always_comb begin
		conflict = lane[0].active && lane[1].active && lane[0].dest == lane[1].dest;
		for (int s = 0; s < SLOT_COUNT; s++) begin
			wr[s].en = !conflict && lane[s].active
				&& ({1'b0, lane[s].dest} < (DEST_W + 1)'(LOOP_REG_COUNT));
			wr[s].dest = lane[s].dest;
			wr[s].data = lane[s].value;
		end
		result.conflict = conflict;
		result.slot0_wrote = wr[0].en;
		result.slot0_result = wr[0].en ? wr[0].data : '0;
		result.slot1_wrote = wr[1].en;
		result.slot1_result = wr[1].en ? wr[1].data : '0;
	end

endmodule

>>> rtl/dsl_checker.sv
module dsl_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input logic          out_valid,
	input logic          out_ready,
	input dsl_pkg::out_t out_data
);
	import dsl_pkg::*;

	a_conflict_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.conflict |-> !out_data.slot0_wrote && !out_data.slot1_wrote)
		else $error("conflict reported together with a register write");

	a_idle_result_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.slot0_wrote || out_data.slot0_result == '0)
			&& (out_data.slot1_wrote || out_data.slot1_result == '0))
		else $error("slot result nonzero without a write");

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted transaction produced no result");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("input stalled while the output register can take a result");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

endmodule

bind dual_slot_loop_register_update dsl_checker u_dsl_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data(out_data)
);
